### hw/rtl/empn_pkg.sv
// Shared types, constants and helpers for the embedding mean pool block.
`timescale 1ns / 1ps
package empn_pkg;

   localparam int ROWS_DEFAULT      = 4096;
   localparam int DIM_DEFAULT       = 64;
   localparam int TOKEN_CAP_DEFAULT = 512;

   localparam int ID_W   = 16;
   localparam int ELEM_W = 6;
   localparam int WGT_W  = 16;
   localparam int ACC_W  = 26;
   localparam int CNT_W  = 10;
   localparam int CFG_W  = 16;

   // Operation codes
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_TOKEN  = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Register indexes
   localparam logic [1:0] REG_ROWS_IN_USE   = 2'd0;
   localparam logic [1:0] REG_UNKNOWN_TOKEN = 2'd1;
   localparam logic [1:0] REG_NORMALIZE_ON  = 2'd2;

   // Output mode chosen at finish
   typedef enum logic [1:0] {
      MODE_MEAN  = 2'd0,
      MODE_ZERO  = 2'd1,
      MODE_FLOOR = 2'd2,
      MODE_NORM  = 2'd3
   } mode_type;

   // Request to the shared divider
   typedef struct packed {
      logic        start;
      logic        neg;
      logic [63:0] num_mag;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        busy;
      logic [63:0] quot;
   } div_rsp_type;

endpackage

### hw/rtl/embedding_mean_pool_l2_norm_top.sv
// Embedding bag mean pooling with optional L2 normalization, top level.
`timescale 1ns / 1ps
// After reset the block clears its accumulator RAM and accepts no word
// meanwhile. Table load words (operation 0) are written while the block is
// idle. A token id reads its row and the accumulators one element per cycle
// from registered RAMs, sums them and writes them back. A finish item sums
// squares and picks the output mode (when normalizing) and takes the square
// root (full norm only), then each element goes through the one shared
// divider (skipped when the sum of squares is zero) and waits in the output
// register until taken. The block accepts no word while an item is in work.
// The table is undefined after reset and must be loaded before use.
module embedding_mean_pool_l2_norm_top #(
   parameter int ROWS      = empn_pkg::ROWS_DEFAULT,
   parameter int DIM       = empn_pkg::DIM_DEFAULT,
   parameter int TOKEN_CAP = empn_pkg::TOKEN_CAP_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // csr
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // token_id[15:0], load_element[21:16],
                                    // weight_value[37:22], zero fill
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // vector_element[15:0], out_position[21:16],
                                    // tokens_used[31:22]
   output logic        rsp_tlast    // is_last
);

   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int DIM_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int ADDR_W = $clog2(ROWS * DIM);
   localparam int TOK_W  = $clog2(TOKEN_CAP + 1);

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b0_0000_0001,
      ST_IDLE  = 9'b0_0000_0010,
      ST_ACC   = 9'b0_0000_0100,
      ST_SQ    = 9'b0_0000_1000,
      ST_SQRT  = 9'b0_0001_0000,
      ST_DIV   = 9'b0_0010_0000,
      ST_WAIT  = 9'b0_0100_0000,
      ST_EMIT  = 9'b0_1000_0000,
      ST_SHIFT = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Unpacked request fields
   empn_pkg::op_type op;
   logic [15:0] id;
   logic [5:0]  elem;
   logic [15:0] wgt;
   assign op   = empn_pkg::op_type'(req_tuser);
   assign id   = req_tdata[15:0];
   assign elem = req_tdata[21:16];
   assign wgt  = req_tdata[37:22];

   // Configuration registers
   logic [12:0] rows_in_use_ff;
   logic [15:0] unknown_ff;
   logic        norm_on_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= 13'd4096;
         unknown_ff     <= '0;
         norm_on_ff     <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            empn_pkg::REG_ROWS_IN_USE:   rows_in_use_ff <= csr_wr_data[12:0];
            empn_pkg::REG_UNKNOWN_TOKEN: unknown_ff <= csr_wr_data;
            empn_pkg::REG_NORMALIZE_ON:  norm_on_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   logic req_fire;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Sequencer state
   logic [DIM_W:0]        ptr_ff, ptr_in;       // element pointer
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [TOK_W-1:0]      seen_ff, seen_in;
   logic [empn_pkg::CNT_W:0] summed_ff, summed_in;
   logic [63:0]           sq_ff, sq_in;
   empn_pkg::mode_type    mode_ff, mode_in;
   logic [4:0]            half_ff, half_in;
   logic [31:0]           root_ff, root_in;
   logic [15:0]           out_val_ff, out_val_in;
   logic                  sqrt_start;
   logic [63:0]           sqrt_rad;
   logic                  sqrt_done;
   logic [31:0]           sqrt_root;
   empn_pkg::div_req_type div_req;
   empn_pkg::div_rsp_type div_rsp;

   // Embedding table
   logic              tbl_we;
   logic [ADDR_W-1:0] tbl_waddr, tbl_raddr;
   logic [15:0]       tbl_rdata;
   assign tbl_we    = req_fire && (op == empn_pkg::OP_LOAD) &&
                      ({16'd0, id} < 32'(ROWS)) && ({26'd0, elem} < 32'(DIM));
   assign tbl_waddr = ADDR_W'({32'(id) * 32'(DIM)} + 32'(elem));
   // Read ahead at the next pointer so data lines up with ptr_ff
   assign tbl_raddr = ADDR_W'(32'(row_in) * 32'(DIM) + 32'(ptr_in[DIM_W-1:0]));

   empn_ram #(.WIDTH(16), .DEPTH(ROWS * DIM)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (wgt),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   // Accumulator RAM, read at the next pointer so acc_rdata holds entry ptr_ff
   logic                              acc_we;
   logic [DIM_W-1:0]                  acc_waddr;
   logic signed [empn_pkg::ACC_W-1:0] acc_wdata;
   logic signed [empn_pkg::ACC_W-1:0] acc_rdata;

   empn_ram #(.WIDTH(empn_pkg::ACC_W), .DEPTH(DIM)) u_acc (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (acc_waddr),
      .wr_data (acc_wdata),
      .rd_addr (ptr_in[DIM_W-1:0]),
      .rd_data (acc_rdata)
   );

   // Square of the current accumulator
   logic signed [51:0] acc_sq;
   assign acc_sq = acc_rdata * acc_rdata;

   // Largest even shift that keeps sq below 2^62
   logic [5:0] lz;
   always_comb begin
      lz = 6'd0;
      for (int b = 0; b < 64; b++) begin
         if (sq_ff[b]) lz = 6'(63 - b);
      end
   end

   logic [5:0] kshift;
   assign kshift = (lz >= 6'd2) ? ((lz - 6'd2) & 6'b111110) : 6'd0;

   logic [12:0] limit;
   assign limit = (32'(rows_in_use_ff) < 32'(ROWS)) ? rows_in_use_ff : 13'(ROWS);

   logic [20:0] c_sq;
   assign c_sq = 21'(summed_ff) * 21'(summed_ff);

   // Numerator and denominator for the pending division
   logic signed [63:0] s_ext, num;
   logic [63:0]        num_mag, den;
   always_comb begin
      s_ext = 64'(acc_rdata);
      unique case (mode_ff)
         empn_pkg::MODE_FLOOR: num = s_ext <<< 15;
         empn_pkg::MODE_NORM:  num = s_ext <<< (15 + half_ff);
         default:              num = s_ext;
      endcase
      num_mag = num[63] ? (64'd0 - num) : num;
      unique case (mode_ff)
         empn_pkg::MODE_NORM: den = 64'(root_ff);
         default: den = (summed_ff == '0) ? 64'd1 : 64'(summed_ff);
      endcase
   end

   logic signed [63:0] q;
   logic [15:0]        sat;
   assign q   = div_rsp.quot;
   assign sat = (q > 64'sd32767) ? 16'h7FFF :
                (q < -64'sd32768) ? 16'h8000 : q[15:0];

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      row_in     = row_ff;
      seen_in    = seen_ff;
      summed_in  = summed_ff;
      sq_in      = sq_ff;
      mode_in    = mode_ff;
      half_in    = half_ff;
      root_in    = root_ff;
      out_val_in = out_val_ff;
      acc_we     = 1'b0;
      acc_waddr  = ptr_ff[DIM_W-1:0];
      acc_wdata  = '0;
      sqrt_start = 1'b0;
      sqrt_rad   = sq_ff << kshift;
      div_req    = '0;
      div_req.neg     = num[63];
      div_req.num_mag = num_mag;
      div_req.den     = den;
      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one accumulator per cycle after reset
            acc_we = 1'b1;
            if (32'(ptr_ff) == DIM - 1) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire && op == empn_pkg::OP_TOKEN && id != unknown_ff &&
                32'(seen_ff) < 32'(TOKEN_CAP)) begin
               seen_in = seen_ff + TOK_W'(1);
               if ({1'b0, id} < {4'd0, limit}) begin
                  row_in   = ROW_W'(id);
                  ptr_in   = '0;
                  state_in = ST_ACC;
               end
            end else if (req_fire && op == empn_pkg::OP_FINISH) begin
               ptr_in  = '0;
               sq_in   = '0;
               mode_in = empn_pkg::MODE_MEAN;
               if (norm_on_ff) state_in = ST_SQ;
               else            state_in = ST_DIV;
            end
         end
         ST_ACC: begin
            // Add one table element into its accumulator
            acc_we    = 1'b1;
            acc_wdata = acc_rdata + empn_pkg::ACC_W'(signed'(tbl_rdata));
            if (32'(ptr_ff) == DIM - 1) begin
               summed_in = summed_ff + 1'b1;
               state_in  = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_SQ: begin
            sq_in = sq_ff + 64'(acc_sq);
            if (32'(ptr_ff) == DIM - 1) state_in = ST_SHIFT;
            else                        ptr_in = ptr_ff + 1'b1;
         end
         ST_SHIFT: begin
            ptr_in = '0;
            if (sq_ff == '0) begin
               mode_in  = empn_pkg::MODE_ZERO;
               state_in = ST_DIV;
            end else if (sq_ff < 64'(c_sq)) begin
               mode_in  = empn_pkg::MODE_FLOOR;
               state_in = ST_DIV;
            end else begin
               mode_in    = empn_pkg::MODE_NORM;
               half_in    = kshift[5:1];
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               root_in  = sqrt_root;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (mode_ff == empn_pkg::MODE_ZERO) begin
               out_val_in = '0;
               state_in   = ST_EMIT;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               out_val_in = sat;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Hold the word until taken, then clear its accumulator
            if (rsp_tready) begin
               acc_we = 1'b1;
               if (32'(ptr_ff) == DIM - 1) begin
                  seen_in   = '0;
                  summed_in = '0;
                  state_in  = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         ptr_ff    <= '0;
         seen_ff   <= '0;
         summed_ff <= '0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         seen_ff   <= seen_in;
         summed_ff <= summed_in;
      end
      row_ff     <= row_in;
      sq_ff      <= sq_in;
      mode_ff    <= mode_in;
      half_ff    <= half_in;
      root_ff    <= root_in;
      out_val_ff <= out_val_in;
   end

   empn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   empn_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Result word
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {summed_ff[empn_pkg::CNT_W-1:0], 6'(ptr_ff[DIM_W-1:0]), out_val_ff};
   assign rsp_tlast  = (32'(ptr_ff) == DIM - 1);

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request accepted while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(summed_ff) <= 32'(seen_ff))
      else $error("summed rows exceed taken ids");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (seen_ff == '0 && summed_ff == '0))
      else $error("pool state not cleared after last word");
`endif

endmodule

### hw/rtl/empn_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module empn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/empn_div.sv
// Shared restoring divider with round-to-nearest, one quotient bit per cycle.
`timescale 1ns / 1ps
module empn_div (
   input  logic                  clock,
   input  logic                  reset,
   input  empn_pkg::div_req_type req,
   output empn_pkg::div_rsp_type rsp
);

   // The dividend is (2*mag + den), divisor 2*den; 66-bit quantities.
   logic [65:0] rem_ff,  rem_in;
   logic [65:0] num_ff,  num_in;
   logic [65:0] den_ff,  den_in;
   logic [65:0] quo_ff,  quo_in;
   logic [6:0]  cnt_ff,  cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff,  neg_in;
   logic [66:0] trial;
   logic [65:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      shifted = {rem_ff[64:0], num_ff[65]};
      trial   = {1'b0, shifted} - {1'b0, den_ff};
      if (req.start) begin
         // Load dividend and divisor
         num_in  = {1'b0, req.num_mag, 1'b0} + {2'b00, req.den};
         den_in  = {1'b0, req.den, 1'b0};
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 7'd66;
         busy_in = 1'b1;
         neg_in  = req.neg;
      end else if (busy_ff) begin
         // One quotient bit per cycle
         num_in = {num_ff[64:0], 1'b0};
         if (!trial[66]) begin
            rem_in = trial[65:0];
            quo_in = {quo_ff[64:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[64:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   // Apply sign to the rounded magnitude
   assign rsp.done = done_ff;
   assign rsp.busy = busy_ff;
   assign rsp.quot = neg_ff ? (64'd0 - quo_ff[63:0]) : quo_ff[63:0];

endmodule

### hw/rtl/empn_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module empn_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] val_ff, val_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] sum;

   always_comb begin
      val_in  = val_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum     = res_ff + bit_ff;
      if (start) begin
         val_in  = radicand;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Test one bit pair
         if (val_ff >= sum) begin
            val_in = val_ff - sum;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff <= val_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule
